// ===== sv/sbcr_pkg.sv =====
// Package for the score based cache replacement block.
// Holds sizes, register codes, reset values, beat types and the command
// and status structs shared by the controller and the datapath.
`default_nettype none

package sbcr_pkg;

  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 8;
  localparam int SCORE_BITS = 10;

  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int ROW_W      = NUM_WAYS * SCORE_BITS;
  localparam int ECNT_W     = $clog2(NUM_WAYS + 1);
  localparam int ARITH_W    = 18;

  localparam int WAY_W      = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_W      = 10;
  localparam int INT_W      = 16;
  localparam int LFSR_W     = 16;
  localparam int STEP_W     = $clog2(LFSR_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCORE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_BONUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP = 3'd4;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 10'd512;
  localparam logic [CFG_W-1:0] MAX_SCORE_RST = 10'd1023;
  localparam logic [CFG_W-1:0] HIT_BONUS_RST = 10'd40;
  localparam logic [INT_W-1:0] INTERVAL_RST  = 16'd1024;
  localparam logic [CFG_W-1:0] INIT_STEP_RST = 10'd16;

  typedef struct packed {
    logic             action;
    logic [5:0]       set_index;
    logic [WAY_W-1:0] way_index;
    logic             hit;
  } item_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             under_threshold_found;
    logic [CNT_W-1:0] eligible_count;
    logic [CFG_W-1:0] current_initial_score;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic rd_row;
    logic eval;
    logic mod_step;
    logic pick;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_victim;
    logic any_elig;
    logic mod_last;
    logic out_free;
  } status_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_EVAL = 6'b000100,
    ST_MOD  = 6'b001000,
    ST_PICK = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== sv/score_based_cache_replacement.sv =====
// Top level of the score based cache replacement block.
// Depends on sbcr_pkg, sbcr_ctrl and sbcr_datapath.
//
// channel   direction  handshake             beat
// in        input      in_valid/in_ready     item_t (action, set, way, hit)
// out       output     out_valid/out_ready   result_t (victim, found, count, init)
// cfg       input      cfg_we                cfg_idx, cfg_wdata
//
// An access beat passes through idle, read, evaluate and done. A victim beat with eligible
// ways also passes through the 16-step bit-serial remainder of the LFSR and the pick state
// before done. The result loads into the output register as the block leaves done.
// The read of the 64-row score memory is registered before evaluation.
// Reset clears row valid bits at once; no clearing pass. A stalled result holds
// in the output register and the block waits before loading the next one.
`default_nettype none

module score_based_cache_replacement import sbcr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire item_t                 in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output result_t                    out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  sbcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbcr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/sbcr_ctrl.sv =====
// Controller state machine for the score based cache replacement block.
// Depends on sbcr_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module sbcr_ctrl import sbcr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_row = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.is_victim && status_i.any_elig) begin
          state_d = ST_MOD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sbcr_datapath.sv =====
// Datapath for the score based cache replacement block: score memory,
// adaptation counters, LFSR, remainder unit, pick logic and output register.
// Depends on sbcr_pkg; steered by cmd_t from sbcr_ctrl.
`default_nettype none

module sbcr_datapath import sbcr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire item_t                 in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output result_t                    out_data_o
);

  localparam logic [ARITH_W-1:0] MASK = ARITH_W'((1 << SCORE_BITS) - 1);

  logic [CFG_W-1:0] thr_q, max_q, bonus_q, step_cfg_q;
  logic [INT_W-1:0] interval_q;

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic             row_vld_q [NUM_SETS];
  logic [ROW_W-1:0] rd_row_q;
  logic             rd_vld_q;

  item_t            item_q;
  logic [SET_W-1:0] set_addr;

  logic [CFG_W-1:0]  init_q;
  logic              dir_q;
  logic [INT_W-1:0]  acc_cnt_q, prev_miss_q, cur_miss_q;
  logic [LFSR_W-1:0] lfsr_q;

  logic [NUM_WAYS-1:0] elig_q;
  logic [ECNT_W-1:0]   cnt_q;
  logic [ECNT_W-1:0]   rem_q;
  logic [STEP_W-1:0]   step_q;
  logic [WAY_W-1:0]    pick_way_q;
  logic                found_q;

  logic              out_valid_q;
  result_t           out_q;

  logic [ROW_W-1:0]    row_new;
  logic [NUM_WAYS-1:0] elig_c;
  logic [ECNT_W-1:0]   cnt_c;
  logic [WAY_W-1:0]    best_c;
  logic [LFSR_W-1:0]   lfsr_nx;
  logic [INT_W-1:0]    acc_nx, miss_nx;
  logic                wrap_c, dir_nx;
  logic [CFG_W-1:0]    init_nx;
  logic [ECNT_W:0]     rem_sh, rem_nx;
  logic [WAY_W-1:0]    pick_c;

  assign set_addr = item_q.set_index[SET_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESHOLD_RST;
      max_q      <= MAX_SCORE_RST;
      bonus_q    <= HIT_BONUS_RST;
      interval_q <= INTERVAL_RST;
      step_cfg_q <= INIT_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q      <= cfg_wdata_i[CFG_W-1:0];
        REG_MAX_SCORE: max_q      <= cfg_wdata_i[CFG_W-1:0];
        REG_HIT_BONUS: bonus_q    <= cfg_wdata_i[CFG_W-1:0];
        REG_INTERVAL:  interval_q <= cfg_wdata_i[INT_W-1:0];
        REG_INIT_STEP: step_cfg_q <= cfg_wdata_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [ARITH_W-1:0] ceil_v, s, t, best_v;
    logic [ARITH_W:0]   sum;
    ceil_v  = (ARITH_W'(max_q) < MASK) ? ARITH_W'(max_q) : MASK;
    row_new = '0;
    elig_c  = '0;
    cnt_c   = '0;
    best_c  = '0;
    best_v  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      s = rd_vld_q ? ARITH_W'(rd_row_q[w*SCORE_BITS +: SCORE_BITS]) : '0;
      if (ARITH_W'(w) == ARITH_W'(item_q.way_index)) begin
        if (item_q.hit) begin
          t = s + ARITH_W'(bonus_q);
          t = (t > ceil_v) ? ceil_v : t;
        end else begin
          t = (ARITH_W'(init_q) > MASK) ? MASK : ARITH_W'(init_q);
        end
      end else begin
        t = (s != '0) ? s - ARITH_W'(1) : s;
      end
      row_new[w*SCORE_BITS +: SCORE_BITS] = t[SCORE_BITS-1:0];
      elig_c[w] = s < ARITH_W'(thr_q);
      cnt_c     = cnt_c + ECNT_W'(elig_c[w]);
      if (w == 0 || s < best_v) begin
        best_v = s;
        best_c = WAY_W'(w);
      end
    end

    lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

    acc_nx  = acc_cnt_q + INT_W'(1);
    miss_nx = (!item_q.hit && cur_miss_q != '1) ? cur_miss_q + INT_W'(1) : cur_miss_q;
    wrap_c  = acc_nx == interval_q;
    dir_nx  = dir_q ^ (miss_nx > prev_miss_q);
    sum     = '0;
    if (dir_nx) begin
      sum = (ARITH_W+1)'(init_q) + (ARITH_W+1)'(step_cfg_q);
      if (sum > (ARITH_W+1)'(max_q)) begin
        sum = (ARITH_W+1)'(max_q);
      end
    end else begin
      if ((ARITH_W+1)'(init_q) > (ARITH_W+1)'(step_cfg_q)) begin
        sum = (ARITH_W+1)'(init_q) - (ARITH_W+1)'(step_cfg_q);
        if (sum > (ARITH_W+1)'(max_q)) begin
          sum = (ARITH_W+1)'(max_q);
        end
      end
    end
    init_nx = sum[CFG_W-1:0];
  end

  always_comb begin
    rem_sh = {rem_q, lfsr_q[~step_q]};
    rem_nx = (rem_sh >= {1'b0, cnt_q}) ? rem_sh - {1'b0, cnt_q} : rem_sh;
  end

  always_comb begin
    logic [ECNT_W-1:0] seen;
    logic              hit_v;
    seen   = '0;
    hit_v  = 1'b0;
    pick_c = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (elig_q[w] && !hit_v) begin
        if (seen == rem_q) begin
          pick_c = WAY_W'(w);
          hit_v  = 1'b1;
        end
        seen = seen + ECNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.rd_row) begin
      rd_row_q <= mem[set_addr];
    end
    if (cmd_i.eval && !item_q.action) begin
      mem[set_addr] <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        row_vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rd_row) begin
        rd_vld_q <= row_vld_q[set_addr];
      end
      if (cmd_i.eval && !item_q.action) begin
        row_vld_q[set_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      dir_q       <= 1'b0;
      acc_cnt_q   <= '0;
      prev_miss_q <= '0;
      cur_miss_q  <= '0;
      lfsr_q      <= LFSR_SEED;
    end else if (cmd_i.eval) begin
      if (!item_q.action) begin
        if (wrap_c) begin
          init_q      <= init_nx;
          dir_q       <= dir_nx;
          acc_cnt_q   <= '0;
          prev_miss_q <= miss_nx;
          cur_miss_q  <= '0;
        end else begin
          acc_cnt_q  <= acc_nx;
          cur_miss_q <= miss_nx;
        end
      end else begin
        lfsr_q <= lfsr_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      elig_q     <= elig_c;
      rem_q      <= '0;
      step_q     <= '0;
      cnt_q      <= item_q.action ? cnt_c : '0;
      pick_way_q <= item_q.action ? best_c : '0;
      found_q    <= 1'b0;
    end
    if (cmd_i.mod_step) begin
      rem_q  <= rem_nx[ECNT_W-1:0];
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.pick) begin
      pick_way_q <= pick_c;
      found_q    <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.victim_way            <= pick_way_q;
      out_q.under_threshold_found <= found_q;
      out_q.eligible_count        <= CNT_W'(cnt_q);
      out_q.current_initial_score <= init_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.is_victim = item_q.action;
  assign status_o.any_elig  = cnt_c != '0;
  assign status_o.mod_last  = step_q == STEP_W'(LFSR_W - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/sbcr_checker.sv =====
// Checker for the score based cache replacement block: watches both beat channels
// and the register port, predicts each result and compares field by field.
// Depends on sbcr_pkg.
`timescale 1ns / 1ps

module sbcr_checker import sbcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  item_t                 in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  result_t               out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [SCORE_BITS-1:0] score_mem [NUM_SETS*NUM_WAYS];
  logic [CFG_W-1:0]      init_score;
  logic                  dir_up;
  logic [INT_W-1:0]      acc_count;
  logic [INT_W-1:0]      prev_miss;
  logic [INT_W-1:0]      cur_miss;
  logic [LFSR_W-1:0]     lfsr;
  logic [CFG_W-1:0]      thr_r, max_r, bonus_r, step_r;
  logic [INT_W-1:0]      intv_r;
  result_t               victim_q [$];

  function automatic result_t predict_victim_pick(item_t it);
    result_t r;
    int base, cnt, best, pick, seen, v;
    logic fb;
    r = '0;
    base = int'(it.set_index) * NUM_WAYS;
    if (it.action == 1'b0) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        v = score_mem[base+w];
        if (w == it.way_index) begin
          if (it.hit) begin
            v = v + int'(bonus_r);
            if (v > int'(max_r)) v = int'(max_r);
          end else begin
            v = init_score;
          end
        end else if (v > 0) begin
          v = v - 1;
        end
        score_mem[base+w] = v[SCORE_BITS-1:0];
      end
      acc_count = acc_count + 1'b1;
      if (!it.hit && cur_miss != 16'hFFFF) cur_miss = cur_miss + 1'b1;
      if (acc_count == intv_r) begin
        v = init_score;
        if (cur_miss > prev_miss) dir_up = ~dir_up;
        v = dir_up ? v + int'(step_r) : v - int'(step_r);
        if (v > int'(max_r)) v = int'(max_r);
        if (v < 0) v = 0;
        init_score = v[CFG_W-1:0];
        prev_miss = cur_miss;
        cur_miss = '0;
        acc_count = '0;
      end
    end else begin
      fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
      lfsr = {fb, lfsr[LFSR_W-1:1]};
      cnt = 0;
      best = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (score_mem[base+w] < thr_r) cnt++;
        if (score_mem[base+w] < score_mem[base+best]) best = w;
      end
      if (cnt > 0) begin
        pick = int'(lfsr) % cnt;
        seen = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (score_mem[base+w] < thr_r) begin
            if (seen == pick) begin
              r.victim_way = w[WAY_W-1:0];
              break;
            end
            seen++;
          end
        end
        r.under_threshold_found = 1'b1;
      end else begin
        r.victim_way = best[WAY_W-1:0];
      end
      r.eligible_count = cnt[CNT_W-1:0];
    end
    r.current_initial_score = init_score;
    return r;
  endfunction

  assign pending_o = victim_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      foreach (score_mem[i]) score_mem[i] = '0;
      init_score = '0;
      dir_up = 1'b0;
      acc_count = '0;
      prev_miss = '0;
      cur_miss = '0;
      lfsr = LFSR_SEED;
      thr_r = THRESHOLD_RST;
      max_r = MAX_SCORE_RST;
      bonus_r = HIT_BONUS_RST;
      intv_r = INTERVAL_RST;
      step_r = INIT_STEP_RST;
      victim_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (victim_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          exp_r = victim_q.pop_front();
          if (out_data_i.victim_way !== exp_r.victim_way) begin
            $error("victim_way exp %0d got %0d", exp_r.victim_way, out_data_i.victim_way);
            fail_count_o++;
          end
          if (out_data_i.under_threshold_found !== exp_r.under_threshold_found) begin
            $error("under_threshold_found exp %0d got %0d",
                   exp_r.under_threshold_found, out_data_i.under_threshold_found);
            fail_count_o++;
          end
          if (out_data_i.eligible_count !== exp_r.eligible_count) begin
            $error("eligible_count exp %0d got %0d",
                   exp_r.eligible_count, out_data_i.eligible_count);
            fail_count_o++;
          end
          if (out_data_i.current_initial_score !== exp_r.current_initial_score) begin
            $error("current_initial_score exp %0d got %0d",
                   exp_r.current_initial_score, out_data_i.current_initial_score);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) victim_q.push_back(predict_victim_pick(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr_r = cfg_wdata_i[CFG_W-1:0];
          REG_MAX_SCORE: max_r = cfg_wdata_i[CFG_W-1:0];
          REG_HIT_BONUS: bonus_r = cfg_wdata_i[CFG_W-1:0];
          REG_INTERVAL:  intv_r = cfg_wdata_i;
          REG_INIT_STEP: step_r = cfg_wdata_i[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the score based cache replacement testbench: clock, reset, register
// writes, access and victim beats, output stalls and the verdict.
// Depends on sbcr_pkg, score_based_cache_replacement and sbcr_checker.
`timescale 1ns / 1ps

module tb_top;
  import sbcr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  item_t                 in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_off = 0;
  int                    cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  score_based_cache_replacement u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  sbcr_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic send_beat(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic item_t rand_item(input int victim_pct, input int hot_sets);
    item_t it;
    it.action = ($urandom_range(99) < victim_pct);
    it.set_index = (hot_sets > 0) ? 6'($urandom_range(hot_sets - 1)) : 6'($urandom);
    it.way_index = 3'($urandom);
    it.hit = $urandom_range(99) < 60;
    return it;
  endfunction

  task automatic set_regs(input int thr, input int mx, input int bn, input int iv,
                          input int st);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_MAX_SCORE, CFG_DATA_W'(mx));
    write_reg(REG_HIT_BONUS, CFG_DATA_W'(bn));
    write_reg(REG_INTERVAL, CFG_DATA_W'(iv));
    write_reg(REG_INIT_STEP, CFG_DATA_W'(st));
    cfg_we <= 1'b0;
  endtask

  initial begin
    item_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs(1023, 1023, 1023, 1, 1023);
    for (int k = 0; k < 24; k++) begin
      it.action = k[0];
      it.set_index = (k < 12) ? 6'd63 : 6'd0;
      it.way_index = (k % 3 == 0) ? 3'd7 : 3'd0;
      it.hit = k[1];
      send_beat(it);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (ph)
        0: set_regs(512, 1023, 40, 1024, 16);
        1: set_regs(0, 1, 0, 1, 0);
        2: set_regs(300, 600, 100, 7, 50);
        3: set_regs(1023, 1023, 1023, 3, 1023);
        4: set_regs(20, 100, 5, 65535, 2);
        5: set_regs(200, 50, 30, 0, 1023);
        default: set_regs($urandom_range(1023), $urandom_range(1023, 1),
                          $urandom_range(1023), $urandom_range(40, 1),
                          $urandom_range(1023));
      endcase
      if (ph == 2) hold_off = 300;
      for (int n = 0; n < 190; n++) send_beat(rand_item(35, (ph % 2) ? 4 : 0));
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
